/* rtl/ilsw_pkg.sv */
// Shared types, constants and helpers for the inverse Laplacian spectral weight unit.
package ilsw_pkg;

    localparam int MAX_DIM    = 512;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int SIZE_W     = 10;
    localparam int HW_W       = 9;
    localparam int DEN_W      = 64;
    localparam int QUO_W      = 57;
    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd7;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic [31:0]     coef_re;
        logic [31:0]     coef_im;
        logic            last;
        logic [DEN_W-1:0] den;
    } job_t;

    typedef struct packed {
        logic [31:0] weight_x;
        logic [31:0] weight_y;
        logic [31:0] weight_z;
        logic [31:0] alpha;
        logic [31:0] gain_num;
        logic [SIZE_W-1:0] size_z;
        logic [SIZE_W-1:0] size_y;
        logic [HW_W-1:0]   half_width;
    } cfg_t;

    // Clamp a size register into [2, hi].
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(2)) r = SIZE_W'(2);
        else if (v > hi)    r = hi;
        return r;
    endfunction

    // Fold an index to its signed frequency magnitude.
    function automatic logic [IDX_W-1:0] fold(input logic [IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] n);
        logic [IDX_W-1:0] r;
        if ({1'b0, idx} <= (n >> 1)) r = idx;
        else                          r = IDX_W'(n - {1'b0, idx});
        return r;
    endfunction

endpackage

/* rtl/ilsw_front.sv */
// Front part: bin index tracking and denominator build, with a small multiply pipeline.
module ilsw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ilsw_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         coef_re,
    input  logic [31:0]         coef_im,
    input  logic                volume_start,
    output logic                job_valid,
    input  logic                job_ready,
    output ilsw_pkg::job_t      job
);

    localparam int W = ilsw_pkg::IDX_W;
    localparam int S = ilsw_pkg::SIZE_W;

    logic [W-1:0] bin_x_reg, bin_x_next;
    logic [W-1:0] bin_y_reg, bin_y_next;
    logic [W-1:0] bin_z_reg, bin_z_next;

    // Stage 1 registers: x index and folded y, z indices squared.
    logic         s1_valid_reg;
    logic [31:0]  s1_re_reg, s1_im_reg;
    logic         s1_last_reg;
    logic [2*W-1:0] s1_ix_reg, s1_jy_reg, s1_kz_reg;
    // Stage 2 registers: weighted terms.
    logic         s2_valid_reg;
    logic [31:0]  s2_re_reg, s2_im_reg;
    logic         s2_last_reg;
    logic [2*W+31:0] s2_tx_reg, s2_ty_reg, s2_tz_reg;

    logic [S-1:0] nz, ny, nx;
    logic [W-1:0] cx, cy, cz, j1, k1;
    logic         last;
    logic         adv;
    logic         fire;

    assign nz = ilsw_pkg::clamp_size(cfg.size_z, S'(ilsw_pkg::MAX_DIM));
    assign ny = ilsw_pkg::clamp_size(cfg.size_y, S'(ilsw_pkg::MAX_DIM));
    assign nx = ilsw_pkg::clamp_size(S'(cfg.half_width), S'(ilsw_pkg::MAX_DIM / 2 + 1));

    // Pipeline advances whenever the output slot is free or drains.
    assign adv      = !s2_valid_reg || job_ready;
    assign in_ready = adv;
    assign fire     = in_valid && in_ready;

    // Current indices after volume start and stale-index handling.
    always_comb
    begin
        cx = volume_start ? '0 : bin_x_reg;
        cy = volume_start ? '0 : bin_y_reg;
        cz = volume_start ? '0 : bin_z_reg;
        if ({1'b0, cx} >= nx) cx = '0;
        if ({1'b0, cy} >= ny) cy = '0;
        if ({1'b0, cz} >= nz) cz = '0;
        j1 = ilsw_pkg::fold(cy, ny);
        k1 = ilsw_pkg::fold(cz, nz);
        last = ({1'b0, cx} == nx - S'(1)) && ({1'b0, cy} == ny - S'(1))
            && ({1'b0, cz} == nz - S'(1));
        // Each index wraps after its last bin; compared before the increment so
        // that an index of 511 never overflows its register.
        bin_x_next = cx + W'(1);
        bin_y_next = cy;
        bin_z_next = cz;
        if ({1'b0, cx} == nx - S'(1))
        begin
            bin_x_next = '0;
            bin_y_next = cy + W'(1);
            if ({1'b0, cy} == ny - S'(1))
            begin
                bin_y_next = '0;
                bin_z_next = cz + W'(1);
                if ({1'b0, cz} == nz - S'(1)) bin_z_next = '0;
            end
        end
    end

    // Index counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_x_reg <= '0;
            bin_y_reg <= '0;
            bin_z_reg <= '0;
        end
        else if (fire)
        begin
            bin_x_reg <= bin_x_next;
            bin_y_reg <= bin_y_next;
            bin_z_reg <= bin_z_next;
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload of the two stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_re_reg   <= coef_re;
            s1_im_reg   <= coef_im;
            s1_last_reg <= last;
            s1_ix_reg   <= cx * cx;
            s1_jy_reg   <= j1 * j1;
            s1_kz_reg   <= k1 * k1;
            s2_re_reg   <= s1_re_reg;
            s2_im_reg   <= s1_im_reg;
            s2_last_reg <= s1_last_reg;
            s2_tx_reg   <= s1_ix_reg * cfg.weight_x;
            s2_ty_reg   <= s1_jy_reg * cfg.weight_y;
            s2_tz_reg   <= s1_kz_reg * cfg.weight_z;
        end
    end

    logic [31:0] alpha_eff;
    assign alpha_eff = (cfg.alpha == '0) ? 32'd1 : cfg.alpha;

    assign job_valid   = s2_valid_reg;
    assign job.coef_re = s2_re_reg;
    assign job.coef_im = s2_im_reg;
    assign job.last    = s2_last_reg;
    assign job.den     = 64'(alpha_eff) + 64'(s2_tx_reg) + 64'(s2_ty_reg) + 64'(s2_tz_reg);

endmodule

/* rtl/ilsw_fifo.sv */
// Short queue between the front and back parts.
module ilsw_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ilsw_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ilsw_pkg::job_t rd_data
);

    ilsw_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

endmodule

/* rtl/ilsw_back.sv */
// Back part: restoring divider for the gain, then scaling and saturation of the coefficient.
module ilsw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    gain_num,
    input  logic           job_valid,
    output logic           job_ready,
    input  ilsw_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_re,
    output logic [31:0]    out_im,
    output logic           volume_last
);

    localparam int QW = ilsw_pkg::QUO_W;
    localparam int DW = ilsw_pkg::DEN_W;
    localparam int CW = $clog2(QW + 4);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_SAT  = 6'b001000,
        ST_RND  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]  rem_reg;
    logic [QW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [31:0]  re_reg, im_reg;
    logic         last_reg;
    logic [31:0]  gain_reg;
    logic [63:0]  pre_reg, pim_reg;
    logic         nre_reg, nim_reg;
    logic [31:0]  ore_reg, oim_reg;

    logic [DW:0]  rem_sh;
    logic         ge;
    logic [QW-1:0] num;

    assign num    = {gain_num, 25'd0} >> 1;
    assign rem_sh = {rem_reg[DW-1:0], num[QW-1 - 32'(cnt_reg)]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    // Magnitude of a signed 32-bit value, as an unsigned 32-bit number.
    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Floor shift and saturation of a scaled magnitude.
    function automatic logic [31:0] sat(input logic [63:0] p, input logic neg);
        logic [39:0] q;
        logic [31:0] r;
        if (neg)
        begin
            q = 40'((p + 64'hFFFFFF) >> 24);
            if (q > 40'h80000000) q = 40'h80000000;
            r = ~q[31:0] + 32'd1;
        end
        else
        begin
            q = 40'(p >> 24);
            if (q > 40'h7FFFFFFF) q = 40'h7FFFFFFF;
            r = q[31:0];
        end
        return r;
    endfunction

    assign job_ready   = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign out_re      = ore_reg;
    assign out_im      = oim_reg;
    assign volume_last = last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CW'(QW - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SAT;
            ST_SAT:  state_next = ST_RND;
            ST_RND:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    // Datapath: one quotient bit a cycle, then gain saturation, products and rounding.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                den_reg  <= job.den;
                re_reg   <= job.coef_re;
                im_reg   <= job.coef_im;
                last_reg <= job.last;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg <= {quo_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg + CW'(1);
            end
            ST_MUL:
            begin
                gain_reg <= (quo_reg[QW-1:32] != '0) ? 32'hFFFFFFFF : quo_reg[31:0];
            end
            ST_SAT:
            begin
                pre_reg <= mag(re_reg) * gain_reg;
                pim_reg <= mag(im_reg) * gain_reg;
                nre_reg <= re_reg[31];
                nim_reg <= im_reg[31];
            end
            ST_RND:
            begin
                ore_reg <= sat(pre_reg, nre_reg);
                oim_reg <= sat(pim_reg, nim_reg);
            end
            ST_OUT: ;
            default: ;
        endcase
    end

endmodule

/* rtl/inverse_laplacian_spectral_weight_unit.sv */
// Top level of the inverse Laplacian spectral weight unit.
//
// Usage: coefficients of a 3D half spectrum enter on the s_axis channel in z, y, x
// scan order; each gets gain_numerator / (alpha + weighted squared frequency)
// applied and leaves on m_axis, with tlast marking the last bin of the volume.
// tuser on the input restarts the bin indices at zero for that item.
// Configuration registers are to be written through cfg_we / cfg_index / cfg_data
// only while the block is idle; the block itself does not enforce this.
// The path runs through two front pipeline stages and the queue, then a restoring
// divider that forms one quotient bit per cycle, then states for gain saturation,
// for the products and for rounding, and the output state.
// The single divider takes one item at a time; the front part and a two-entry
// queue accept further items while it works.
// Reset clears the bin indices, the queue and all control state and loads
// the register defaults. When the receiver stalls the result holds on
// m_axis and the queue fills, after which s_axis_tready falls.
module inverse_laplacian_spectral_weight_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coef_re [31:0], coef_im [63:32]
    input  logic        s_axis_tuser,   // volume_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_re [31:0], out_im [63:32]
    output logic        m_axis_tlast
);

    ilsw_pkg::cfg_t cfg_reg;
    ilsw_pkg::job_t f_job, b_job;
    logic f_valid, f_ready, b_valid, b_ready;
    logic [31:0] ore, oim;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_x   <= '0;
            cfg_reg.weight_y   <= '0;
            cfg_reg.weight_z   <= '0;
            cfg_reg.alpha      <= 32'd1;
            cfg_reg.gain_num   <= 32'd16777216;
            cfg_reg.size_z     <= 10'd512;
            cfg_reg.size_y     <= 10'd512;
            cfg_reg.half_width <= 9'd257;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ilsw_pkg::CFG_WEIGHT_X:   cfg_reg.weight_x   <= cfg_data;
                ilsw_pkg::CFG_WEIGHT_Y:   cfg_reg.weight_y   <= cfg_data;
                ilsw_pkg::CFG_WEIGHT_Z:   cfg_reg.weight_z   <= cfg_data;
                ilsw_pkg::CFG_REG_ALPHA:  cfg_reg.alpha      <= cfg_data;
                ilsw_pkg::CFG_GAIN_NUM:   cfg_reg.gain_num   <= cfg_data;
                ilsw_pkg::CFG_SIZE_Z:     cfg_reg.size_z     <= cfg_data[9:0];
                ilsw_pkg::CFG_SIZE_Y:     cfg_reg.size_y     <= cfg_data[9:0];
                ilsw_pkg::CFG_HALF_WIDTH: cfg_reg.half_width <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    ilsw_front u_front (
        .clk, .rst_n, .cfg(cfg_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .coef_re(s_axis_tdata[31:0]), .coef_im(s_axis_tdata[63:32]),
        .volume_start(s_axis_tuser),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    ilsw_fifo u_fifo (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
    );

    ilsw_back u_back (
        .clk, .rst_n, .gain_num(cfg_reg.gain_num),
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_re(ore), .out_im(oim), .volume_last(m_axis_tlast)
    );

    assign m_axis_tdata = {oim, ore};

    // A stalled result keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // A full queue always has an item ready for the back part.
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !f_ready |-> !(b_ready && !b_valid))
        else $error("queue full while back part starved");

endmodule
